@@ hw/rtl/current_command_slew_limiter_assert.svh @@
// Assertion macros shared by the slew limiter. Both sample on clk_i and are
// switched off while rst_ni is low.
`ifndef CURRENT_COMMAND_SLEW_LIMITER_ASSERT_SVH
`define CURRENT_COMMAND_SLEW_LIMITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSCL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cscl_pkg.sv @@
package cscl_pkg;

  localparam int unsigned RATE_W    = 20;
  localparam int unsigned LIMIT_W   = 15;
  localparam int unsigned CUR_W     = 16;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned MODE_W    = 8;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = RATE_W;

  localparam logic [RATE_W-1:0]  BaseRateReset    = RATE_W'(20000);
  localparam logic [RATE_W-1:0]  ReleaseRateReset = '0;
  localparam logic [LIMIT_W-1:0] LimitReset       = LIMIT_W'(3000);

  // A stored mode of all ones means that no mode has been seen yet.
  localparam logic [MODE_W-1:0] NoMode = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgBaseRamp    = 2'd0,
    CfgReleaseRamp = 2'd1,
    CfgLimit       = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CUR_W-1:0]  target_current;
    logic [ELAPSED_W-1:0]     elapsed_us;
    logic [MODE_W-1:0]        ctrl_mode;
    logic                     safety_cut;
  } cmd_in_t;

  typedef struct packed {
    logic signed [CUR_W-1:0] command_current;
    logic                    pid_reset_request;
  } cmd_out_t;

  // Configuration as seen by the datapath; the user must keep it stable while items are in flight (not enforced here).
  typedef struct packed {
    logic [RATE_W-1:0]  base_rate;
    logic [RATE_W-1:0]  release_rate;
    logic [LIMIT_W-1:0] limit;
    logic               base_zero;
    logic               release_zero;
  } cscl_cfg_t;

endpackage

@@ hw/rtl/cscl_stream_if.sv @@
interface cscl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/cscl_step_pipe.sv @@
// Four-stage pipeline that turns the elapsed time of a word into the largest
// allowed step for both ramp rates. The word itself travels alongside.
module cscl_step_pipe
  import cscl_pkg::*;
#(
  parameter int unsigned MAX_ELAPSED_US = 1000,
  localparam int unsigned T_W    = $clog2(MAX_ELAPSED_US + 1),
  localparam int unsigned P_W    = RATE_W + T_W,
  localparam int unsigned STEP_W = P_W - 19
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cscl_cfg_t           cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cmd_in_t             in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cmd_in_t             out_item_o,
  output logic [STEP_W-1:0]   step_base_o,
  output logic [STEP_W-1:0]   step_rel_o
);

  // Division by one million is a multiply by a rounded-up reciprocal of
  // 2^K / 1e6. The rounding error stays below 2^20, so the quotient is exact
  // for every product below 2^P_W.
  localparam int unsigned K     = P_W + 20;
  localparam int unsigned M_W   = P_W + 1;
  localparam int unsigned ML_W  = 18;
  localparam int unsigned MH_W  = M_W - ML_W;
  localparam int unsigned SUM_W = P_W + M_W;
  localparam longint unsigned RecipM =
    ((64'd1 << K) + 64'd999999) / 64'd1000000;
  localparam logic [M_W-1:0]  RecipV  = M_W'(RecipM);
  localparam logic [ML_W-1:0] RecipLo = RecipV[ML_W-1:0];
  localparam logic [MH_W-1:0] RecipHi = RecipV[M_W-1:ML_W];
  localparam logic [T_W-1:0]  MaxT    = T_W'(MAX_ELAPSED_US);

  logic [3:0] v_q, v_d, rdy;
  cmd_in_t    item_q [4];

  logic [T_W-1:0]       t_q, t_d;
  logic [P_W-1:0]       pb_q, pb_d, pr_q, pr_d;
  logic [P_W+ML_W-1:0]  pb_lo_q, pb_lo_d, pr_lo_q, pr_lo_d;
  logic [P_W+MH_W-1:0]  pb_hi_q, pb_hi_d, pr_hi_q, pr_hi_d;
  logic [SUM_W-1:0]     sum_b, sum_r;
  logic [STEP_W-1:0]    sb_q, sb_d, sr_q, sr_d;

  always_comb begin
    rdy[3] = !v_q[3] || out_ready_i;
    for (int k = 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_d[0] = rdy[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < 4; k++) begin
      v_d[k] = rdy[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_comb begin
    if (in_item_i.elapsed_us > ELAPSED_W'(MAX_ELAPSED_US)) begin
      t_d = MaxT;
    end else begin
      t_d = in_item_i.elapsed_us[T_W-1:0];
    end
    pb_d    = P_W'(cfg_i.base_rate) * P_W'(t_q);
    pr_d    = P_W'(cfg_i.release_rate) * P_W'(t_q);
    pb_lo_d = (P_W+ML_W)'(pb_q) * (P_W+ML_W)'(RecipLo);
    pr_lo_d = (P_W+ML_W)'(pr_q) * (P_W+ML_W)'(RecipLo);
    pb_hi_d = (P_W+MH_W)'(pb_q) * (P_W+MH_W)'(RecipHi);
    pr_hi_d = (P_W+MH_W)'(pr_q) * (P_W+MH_W)'(RecipHi);
    sum_b   = {pb_hi_q, {ML_W{1'b0}}} + SUM_W'(pb_lo_q);
    sum_r   = {pr_hi_q, {ML_W{1'b0}}} + SUM_W'(pr_lo_q);
    sb_d    = sum_b[SUM_W-1:K];
    sr_d    = sum_r[SUM_W-1:K];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      item_q[0] <= in_item_i;
      t_q       <= t_d;
    end
    if (rdy[1]) begin
      item_q[1] <= item_q[0];
      pb_q      <= pb_d;
      pr_q      <= pr_d;
    end
    if (rdy[2]) begin
      item_q[2] <= item_q[1];
      pb_lo_q   <= pb_lo_d;
      pr_lo_q   <= pr_lo_d;
      pb_hi_q   <= pb_hi_d;
      pr_hi_q   <= pr_hi_d;
    end
    if (rdy[3]) begin
      item_q[3] <= item_q[2];
      sb_q      <= sb_d;
      sr_q      <= sr_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[3];
  assign out_item_o  = item_q[3];
  assign step_base_o = sb_q;
  assign step_rel_o  = sr_q;

endmodule

@@ hw/rtl/cscl_ramp.sv @@
// Picks release or base ramp, moves the present command toward the target by
// at most one step (onto it at zero rate), applies limit, hold, safety cut.
module cscl_ramp
  import cscl_pkg::*;
#(
  parameter int unsigned STEP_W = 11
) (
  input  logic signed [CUR_W-1:0] cur_i,
  input  cmd_in_t                 item_i,
  input  logic [STEP_W-1:0]       step_base_i,
  input  logic [STEP_W-1:0]       step_rel_i,
  input  cscl_cfg_t               cfg_i,
  output logic signed [CUR_W-1:0] next_o
);

  localparam int unsigned DW = (STEP_W + 2 > CUR_W + 2) ? STEP_W + 2 : CUR_W + 2;

  logic signed [DW-1:0] tgt_x, cur_x, tgt_abs, cur_abs;
  logic signed [DW-1:0] step_x, delta, delta_c, pre, lim_x, clamped;
  logic [STEP_W-1:0]    step;
  logic                 releasing, use_rel, rate_zero;

  always_comb begin
    tgt_x   = DW'(item_i.target_current);
    cur_x   = DW'(cur_i);
    tgt_abs = (tgt_x < 0) ? -tgt_x : tgt_x;
    cur_abs = (cur_x < 0) ? -cur_x : cur_x;

    // Release applies when shrinking in magnitude or crossing through zero.
    releasing = (tgt_abs < cur_abs) || (cur_x < 0 && tgt_x > 0) || (cur_x > 0 && tgt_x < 0);
    use_rel   = releasing && !cfg_i.release_zero;
    rate_zero = use_rel ? 1'b0 : cfg_i.base_zero;
    step      = use_rel ? step_rel_i : step_base_i;
    step_x    = $signed({{(DW-STEP_W){1'b0}}, step});

    delta = tgt_x - cur_x;
    if (delta > step_x) begin
      delta_c = step_x;
    end else if (delta < -step_x) begin
      delta_c = -step_x;
    end else begin
      delta_c = delta;
    end

    pre   = rate_zero ? tgt_x : (cur_x + delta_c);
    lim_x = $signed({{(DW-LIMIT_W){1'b0}}, cfg_i.limit});
    if (pre > lim_x) begin
      clamped = lim_x;
    end else if (pre < -lim_x) begin
      clamped = -lim_x;
    end else begin
      clamped = pre;
    end

    if (item_i.safety_cut) begin
      next_o = '0;
    end else if (!rate_zero && item_i.elapsed_us == '0) begin
      next_o = cur_i;
    end else begin
      next_o = clamped[CUR_W-1:0];
    end
  end

endmodule

@@ hw/rtl/current_command_slew_limiter.sv @@
// Current command slew limiter. Each word on cmd_i carries a target current,
// the elapsed time, a mode and a safety-cut flag; each produces exactly one
// word on cmd_o with the new command and a PID reset request. The block takes
// one word per cycle while cmd_o does not stall; each word passes four
// stages (time clamp, rate multiply, split reciprocal multiply, add and shift)
// that compute the step rate * min(elapsed, MAX_ELAPSED_US) / 1e6 for both
// ramp rates; the output register then applies the step to the stored command
// and shows the result on cmd_o. Stages advance independently, so up to five
// words are held while cmd_o stalls; only when all five are occupied does
// cmd_i drop ready. Configuration writes must only occur while no word is in
// flight.
module current_command_slew_limiter
  import cscl_pkg::*;
#(
  parameter int unsigned MAX_ELAPSED_US = 1000
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  cscl_stream_if.sink           cmd_i,
  cscl_stream_if.source         cmd_o
);

  `include "current_command_slew_limiter_assert.svh"

  localparam int unsigned T_W    = $clog2(MAX_ELAPSED_US + 1);
  localparam int unsigned STEP_W = RATE_W + T_W - 19;

  logic [RATE_W-1:0]  base_q, rel_q;
  logic [LIMIT_W-1:0] limit_q;
  cscl_cfg_t          cfg;

  logic                    pipe_valid, out_rdy, adv;
  cmd_in_t                 pipe_item;
  logic [STEP_W-1:0]       step_base, step_rel;
  logic signed [CUR_W-1:0] next_cur;

  logic                    out_valid_q, out_valid_d;
  logic signed [CUR_W-1:0] cur_q;
  logic                    req_q, req_d;
  logic [MODE_W-1:0]       last_mode_q;
  logic                    last_cut_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BaseRateReset;
      rel_q   <= ReleaseRateReset;
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBaseRamp:    base_q  <= cfg_data_i[RATE_W-1:0];
        CfgReleaseRamp: rel_q   <= cfg_data_i[RATE_W-1:0];
        CfgLimit:       limit_q <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.base_rate    = base_q;
    cfg.release_rate = rel_q;
    cfg.limit        = limit_q;
    cfg.base_zero    = (base_q == '0);
    cfg.release_zero = (rel_q == '0);
  end

  cscl_step_pipe #(
    .MAX_ELAPSED_US(MAX_ELAPSED_US)
  ) u_step_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .in_item_i   (cmd_i.data),
    .out_valid_o (pipe_valid),
    .out_ready_i (out_rdy),
    .out_item_o  (pipe_item),
    .step_base_o (step_base),
    .step_rel_o  (step_rel)
  );

  cscl_ramp #(
    .STEP_W(STEP_W)
  ) u_ramp (
    .cur_i       (cur_q),
    .item_i      (pipe_item),
    .step_base_i (step_base),
    .step_rel_i  (step_rel),
    .cfg_i       (cfg),
    .next_o      (next_cur)
  );

  // The stored command doubles as the output payload; it only moves when a
  // word enters the output register.
  assign out_rdy = !out_valid_q || cmd_o.ready;
  assign adv     = pipe_valid && out_rdy;

  always_comb begin
    req_d = (last_mode_q != NoMode && pipe_item.ctrl_mode != last_mode_q) ||
            (pipe_item.safety_cut && !last_cut_q);
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (cmd_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      req_q       <= 1'b0;
      last_mode_q <= NoMode;
      last_cut_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (adv) begin
        cur_q       <= next_cur;
        req_q       <= req_d;
        last_mode_q <= pipe_item.ctrl_mode;
        last_cut_q  <= pipe_item.safety_cut;
      end
    end
  end

  assign cmd_o.valid                  = out_valid_q;
  assign cmd_o.data.command_current   = cur_q;
  assign cmd_o.data.pid_reset_request = req_q;

  `CSCL_ASSERT_SAME(a_cut_gives_zero, out_valid_q && last_cut_q, cur_q == '0,
                    "safety cut result is not zero")
  `CSCL_ASSERT_NEXT(a_adv_shows_result, adv, out_valid_q,
                    "word taken into output register is not presented")
  `CSCL_ASSERT_NEXT(a_mode_only_on_adv, !adv, $stable(last_mode_q) && $stable(cur_q),
                    "state changed without a word entering the output register")

endmodule
